/* src/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// shared widths, codes and request types of the first-fit block allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PADDR_W  = 3;

  // default geometry
  localparam int unsigned DEF_MAX_BLOCKS   = 64;
  localparam int unsigned DEF_HEADER_BYTES = 24;

  // depth of the request queue between front and back, power of two
  localparam int unsigned CMD_DEPTH = 2;

  // whole heap span, also the reset value of the heap limit
  localparam logic [SIZE_W-1:0] HEAP_SPAN = SIZE_W'(1048576);

  // register word indexes
  localparam logic [0:0] REG_HEAP_LIMIT = 1'b0;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_IGNORED  = 2'd1,
    STATUS_NO_SPACE = 2'd2,
    STATUS_BAD_FREE = 2'd3
  } status_e;

  // classified request handed from front to back
  typedef struct packed {
    mode_e             mode;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
    logic              ignore;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] payload_addr;
    logic              reused;
  } res_t;

endpackage

/* src/ffa_front.sv */
// ----------------------------------------------------------------------------
// ffa_front
// takes requests, marks zero-size allocates and null frees, and queues them
// ----------------------------------------------------------------------------
module ffa_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode_i,
  input  logic [ffa_pkg::SIZE_W-1:0]  req_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0]  free_addr_i,
  output logic                        cmd_vld_o,
  output ffa_pkg::cmd_t               cmd_o,
  input  logic                        cmd_pop_i
);
  import ffa_pkg::*;

  localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t              queue_q [CMD_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              push_ok;
  logic              pop_ok;
  cmd_t              cmd_new;

  // classify
  always_comb begin
    cmd_new.mode      = mode_e'(mode_i);
    cmd_new.req_size  = req_size_i;
    cmd_new.free_addr = free_addr_i;
    if (mode_e'(mode_i) == MODE_ALLOC) begin
      cmd_new.ignore = (req_size_i == '0);
    end else begin
      cmd_new.ignore = (free_addr_i == '0);
    end
  end

  assign full      = (cnt_q == CNT_W'(CMD_DEPTH));
  assign cmd_vld_o = (cnt_q != '0);
  assign cmd_o     = queue_q[rd_ptr_q];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop_i && cmd_vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = wr_ptr_q + PTR_W'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + PTR_W'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!push_ok && pop_ok) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

/* src/ffa_back.sv */
// ----------------------------------------------------------------------------
// ffa_back
// block table engine: first-fit scan, address lookup, append, result register
// ----------------------------------------------------------------------------
module ffa_back #(
  parameter int unsigned MAX_BLOCKS   = ffa_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ffa_pkg::SIZE_W-1:0]  heap_limit_i,
  input  logic                        cmd_vld_i,
  input  ffa_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        res_vld_o,
  output ffa_pkg::res_t               res_o,
  input  logic                        res_pop_i
);
  import ffa_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned END_W = SIZE_W + 1;
  localparam logic [SIZE_W-1:0] HDR     = SIZE_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_BLOCKS);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic              blk_free;
  } entry_t;

  entry_t            table_mem [MAX_BLOCKS];
  entry_t            rd_data_q;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SIZE_W-1:0] top_q, top_d;
  logic              res_vld_q, res_vld_d;
  res_t              res_q, res_d;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              pop_ok;
  logic              slot_free;
  logic [SIZE_W-1:0] limit_eff;
  logic [END_W-1:0]  end_sum;
  logic [SIZE_W-1:0] hit_payload;
  logic [SIZE_W-1:0] new_payload;
  logic              alloc_fit;
  logic              addr_match;
  logic              hit;

  assign pop_ok    = res_pop_i && res_vld_q;
  assign slot_free = !res_vld_q || pop_ok;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_vld_i && slot_free;
  assign rd_en     = (state_q == ST_SCAN) && (issue_q < count_q);
  assign rd_addr   = issue_q[IDX_W-1:0];

  assign limit_eff   = (heap_limit_i > HEAP_SPAN) ? HEAP_SPAN : heap_limit_i;
  assign end_sum     = {1'b0, top_q} + {1'b0, HDR} + {1'b0, cmd_q.req_size};
  assign hit_payload = {1'b0, rd_data_q.base} + HDR;
  assign new_payload = top_q + HDR;
  assign alloc_fit   = rd_data_q.blk_free && (rd_data_q.size >= cmd_q.req_size);
  assign addr_match  = (hit_payload == {1'b0, cmd_q.free_addr});
  assign hit         = chk_vld_q && ((cmd_q.mode == MODE_ALLOC) ? alloc_fit : addr_match);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    issue_d   = issue_q;
    chk_vld_d = chk_vld_q;
    chk_idx_d = chk_idx_q;
    count_d   = count_q;
    top_d     = top_q;
    res_vld_d = res_vld_q && !pop_ok;
    res_d     = res_q;
    wr_en     = 1'b0;
    wr_addr   = chk_idx_q;
    wr_data   = rd_data_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          cmd_d = cmd_i;
          if (cmd_i.ignore) begin
            res_vld_d = 1'b1;
            res_d     = '{status: STATUS_IGNORED, payload_addr: '0, reused: 1'b0};
          end else begin
            state_d   = ST_SCAN;
            issue_d   = '0;
            chk_vld_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        // read one entry a cycle, check it the cycle after
        chk_vld_d = rd_en;
        chk_idx_d = rd_addr;
        if (rd_en) begin
          issue_d = issue_q + CNT_W'(1);
        end
        if (hit) begin
          state_d   = ST_IDLE;
          res_vld_d = 1'b1;
          if (cmd_q.mode == MODE_ALLOC) begin
            wr_en            = 1'b1;
            wr_data.blk_free = 1'b0;
            res_d = '{status: STATUS_OK, payload_addr: hit_payload[ADDR_W-1:0],
                      reused: 1'b1};
          end else if (rd_data_q.blk_free) begin
            res_d = '{status: STATUS_BAD_FREE, payload_addr: '0, reused: 1'b0};
          end else begin
            wr_en            = 1'b1;
            wr_data.blk_free = 1'b1;
            res_d = '{status: STATUS_OK, payload_addr: '0, reused: 1'b0};
          end
        end else if (!chk_vld_q && !rd_en) begin
          // table exhausted
          state_d   = ST_IDLE;
          res_vld_d = 1'b1;
          if (cmd_q.mode == MODE_ALLOC) begin
            if ((count_q == MAX_CNT) || (end_sum > {1'b0, limit_eff})) begin
              res_d = '{status: STATUS_NO_SPACE, payload_addr: '0, reused: 1'b0};
            end else begin
              wr_en   = 1'b1;
              wr_addr = count_q[IDX_W-1:0];
              wr_data = '{base: top_q[ADDR_W-1:0], size: cmd_q.req_size,
                          blk_free: 1'b0};
              count_d = count_q + CNT_W'(1);
              top_d   = end_sum[SIZE_W-1:0];
              res_d   = '{status: STATUS_OK, payload_addr: new_payload[ADDR_W-1:0],
                          reused: 1'b0};
            end
          end else begin
            res_d = '{status: STATUS_BAD_FREE, payload_addr: '0, reused: 1'b0};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chk_vld_q <= 1'b0;
      count_q   <= '0;
      top_q     <= '0;
      res_vld_q <= 1'b0;
      issue_q   <= '0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= chk_vld_d;
      count_q   <= count_d;
      top_q     <= top_d;
      res_vld_q <= res_vld_d;
      issue_q   <= issue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
  end

  // block table, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= table_mem[rd_addr];
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

/* src/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap block allocator with an address-ordered block table
// ----------------------------------------------------------------------------
// Requests enter through a queue port (push/full) and results leave through
// one (pop/empty), one result per request in request order. An allocate
// request takes the first free table entry whose size is at least the
// request, without splitting, and reports it as reused; otherwise it appends
// a block of header plus request at the heap top, failing with no space when
// the heap limit would be passed or the table is full. A free request looks
// up the block by payload address; an unknown address or a double free is
// flagged. Zero-size allocates and null frees come back as ignored. Blocks
// are never coalesced. The front queues requests; the back engine answers an
// ignored request without a table walk, and otherwise walks the table one
// entry per cycle through the single read port of the table memory, ending
// the walk early when a hit is found. The front keeps accepting requests
// while the back works and while a result waits to be popped, until its
// queue of CMD_DEPTH requests is full. The heap limit register sits at
// byte address 0 of the APB port and may only be written while the block
// is idle.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = ffa_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffa_pkg::PADDR_W-1:0]  paddr,
  input  logic [ffa_pkg::DATA_W-1:0]   pwdata,
  output logic [ffa_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic                         mode_i,
  input  logic [ffa_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [ffa_pkg::ADDR_W-1:0]   free_addr_i,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic [ffa_pkg::STATUS_W-1:0] status_o,
  output logic [ffa_pkg::ADDR_W-1:0]   payload_addr_o,
  output logic                         reused_o
);
  import ffa_pkg::*;

  logic [SIZE_W-1:0] heap_limit_q, heap_limit_d;
  logic              cfg_wr;
  logic              cmd_vld;
  cmd_t              cmd;
  logic              cmd_pop;
  logic              res_vld;
  res_t              res;

  // configuration register, word address decoded, low byte bits ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    heap_limit_d = heap_limit_q;
    if (cfg_wr && (paddr[PADDR_W-1:2] == REG_HEAP_LIMIT)) begin
      heap_limit_d = pwdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= HEAP_SPAN;
    end else begin
      heap_limit_q <= heap_limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_HEAP_LIMIT) begin
      prdata = {{(DATA_W - SIZE_W){1'b0}}, heap_limit_q};
    end
  end

  // front: classify and queue requests
  ffa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .req_size_i  (req_size_i),
    .free_addr_i (free_addr_i),
    .cmd_vld_o   (cmd_vld),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: table walk, update and result register
  ffa_back #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_limit_i (heap_limit_q),
    .cmd_vld_i    (cmd_vld),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .res_vld_o    (res_vld),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty          = !res_vld;
  assign status_o       = res.status;
  assign payload_addr_o = res.payload_addr;
  assign reused_o       = res.reused;

  // failures never carry an address or a reuse mark
  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o != STATUS_OK)) |-> ((payload_addr_o == '0) && !reused_o))
    else $error("failed request carries an address or reuse mark");

  // a reused block is always a successful allocate with a real address
  a_reuse_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && reused_o) |-> ((status_o == STATUS_OK) && (payload_addr_o != '0)))
    else $error("reuse reported on a non-successful result");

  // a heap limit write lands in the register
  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (paddr[PADDR_W-1:2] == REG_HEAP_LIMIT))
      |=> (heap_limit_q == $past(pwdata[SIZE_W-1:0])))
    else $error("heap limit write lost");

endmodule
